### hdl/pst_pkg.sv
// package for the positional sequence table: operation codes, controller states,
// field widths and the command and status bundles between controller and datapath
// no dependencies
`timescale 1ns / 1ps

package pst_pkg;

  localparam int OP_W      = 3;
  localparam int POS_W     = 7;
  localparam int VALUE_W   = 32;
  localparam int RPOS_W    = 6;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT     = 3'd0,
    OP_INSERT_SORTED = 3'd1,
    OP_ERASE_AT      = 3'd2,
    OP_REMOVE_ALL    = 3'd3,
    OP_GET           = 3'd4,
    OP_SET           = 3'd5,
    OP_FIND          = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_COMPACT,
    ST_GET_RD,
    ST_GET_DATA,
    ST_SET,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;            // capture a new transaction, clear the working result
    logic src_top;         // with load: start the read pointer at the count
    logic cmp_ge;          // scan stops on item >= value instead of item == value
    logic skip_pos;        // compaction drops the entry at the position
    logic report_removed;  // compaction reports the number dropped
    logic scan_run;
    logic take_scan;       // insert position from the scan outcome
    logic shift_init;
    logic shift_run;
    logic put;             // write the value at the insert position
    logic find_take;
    logic compact_run;
    logic compact_fin;
    logic get_rd;
    logic get_take;
    logic set_wr;
    logic send;            // move the working result to the output register
  } cmd_t;

  typedef struct packed {
    logic pos_le;      // input position <= count
    logic pos_lt;      // input position < count
    logic full;
    logic hit;         // data from memory matches this cycle
    logic reads_done;  // upward pass finished, nothing in flight
    logic shift_end;   // downward pass finished, nothing in flight
    logic out_free;
  } status_t;

endpackage

### hdl/pst_ram.sv
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
`timescale 1ns / 1ps

module pst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/pst_controller.sv
// controller state machine of the positional sequence table
// depends on pst_pkg for operation codes, states and the command and status bundles
`timescale 1ns / 1ps

module pst_controller (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pst_pkg::OP_W-1:0]     operation,
  input  pst_pkg::status_t             st,
  output pst_pkg::cmd_t                cmd
);

  pst_pkg::state_t state, state_next;
  pst_pkg::op_t    op_r, op_r_next;
  logic            sorted;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_r_next;
  end

  assign sorted = (op_r == pst_pkg::OP_INSERT_SORTED);

  always_comb begin
    state_next         = state;
    op_r_next          = op_r;
    cmd                = '0;
    cmd.cmp_ge         = sorted;
    cmd.skip_pos       = (op_r == pst_pkg::OP_ERASE_AT);
    cmd.report_removed = (op_r == pst_pkg::OP_REMOVE_ALL);
    in_stall           = (state != pst_pkg::ST_IDLE);

    unique case (state)
      pst_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          op_r_next   = pst_pkg::op_t'(operation);
          cmd.src_top = (pst_pkg::op_t'(operation) == pst_pkg::OP_INSERT_AT);
          unique case (pst_pkg::op_t'(operation))
            pst_pkg::OP_INSERT_AT:
              state_next = (st.pos_le && !st.full) ? pst_pkg::ST_SHIFT : pst_pkg::ST_FINISH;
            pst_pkg::OP_INSERT_SORTED:
              state_next = !st.full ? pst_pkg::ST_SCAN : pst_pkg::ST_FINISH;
            pst_pkg::OP_ERASE_AT:
              state_next = st.pos_lt ? pst_pkg::ST_COMPACT : pst_pkg::ST_FINISH;
            pst_pkg::OP_REMOVE_ALL: state_next = pst_pkg::ST_COMPACT;
            pst_pkg::OP_GET:
              state_next = st.pos_lt ? pst_pkg::ST_GET_RD : pst_pkg::ST_FINISH;
            pst_pkg::OP_SET:
              state_next = st.pos_lt ? pst_pkg::ST_SET : pst_pkg::ST_FINISH;
            pst_pkg::OP_FIND:       state_next = pst_pkg::ST_SCAN;
            default:                state_next = pst_pkg::ST_FINISH;
          endcase
        end
      end
      pst_pkg::ST_SCAN: begin
        priority if (st.hit || st.reads_done) begin
          if (sorted) begin
            cmd.take_scan  = 1'b1;
            cmd.shift_init = 1'b1;
            state_next     = pst_pkg::ST_SHIFT;
          end else begin
            cmd.find_take = st.hit;
            state_next    = pst_pkg::ST_FINISH;
          end
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      pst_pkg::ST_SHIFT: begin
        if (st.shift_end) begin
          cmd.put    = 1'b1;
          state_next = pst_pkg::ST_FINISH;
        end else begin
          cmd.shift_run = 1'b1;
        end
      end
      pst_pkg::ST_COMPACT: begin
        if (st.reads_done) begin
          cmd.compact_fin = 1'b1;
          state_next      = pst_pkg::ST_FINISH;
        end else begin
          cmd.compact_run = 1'b1;
        end
      end
      pst_pkg::ST_GET_RD: begin
        cmd.get_rd = 1'b1;
        state_next = pst_pkg::ST_GET_DATA;
      end
      pst_pkg::ST_GET_DATA: begin
        cmd.get_take = 1'b1;
        state_next   = pst_pkg::ST_FINISH;
      end
      pst_pkg::ST_SET: begin
        cmd.set_wr = 1'b1;
        state_next = pst_pkg::ST_FINISH;
      end
      pst_pkg::ST_FINISH: begin
        if (st.out_free) begin
          cmd.send   = 1'b1;
          state_next = pst_pkg::ST_IDLE;
        end
      end
      default: state_next = pst_pkg::ST_IDLE;
    endcase
  end

  // a pass only ever runs in its own state
  assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_run || cmd.take_scan) |-> (state == pst_pkg::ST_SCAN))
    else $error("scan command outside scan state");

  assert property (@(posedge clk) disable iff (rst)
    (state == pst_pkg::ST_FINISH) && st.out_free |=> (state == pst_pkg::ST_IDLE))
    else $error("finish did not return to idle");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == pst_pkg::ST_IDLE) && !in_stall)
    else $error("transaction loaded while busy");

endmodule

### hdl/pst_datapath.sv
// datapath of the positional sequence table: item memory, count, read and write
// pointers, match logic and the result and output registers
// depends on pst_pkg and pst_ram
`timescale 1ns / 1ps

module pst_datapath #(
  parameter int CAPACITY   = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [pst_pkg::POS_W-1:0]         position,
  input  logic [pst_pkg::VALUE_W-1:0]       item_value,
  input  logic                              out_stall,
  input  pst_pkg::cmd_t                     cmd,
  output pst_pkg::status_t                  st,
  output logic                              out_valid,
  output logic                              ok,
  output logic [pst_pkg::RPOS_W-1:0]        result_position,
  output logic [pst_pkg::VALUE_W-1:0]       result_value,
  output logic [pst_pkg::CNT_OUT_W-1:0]     removed_count,
  output logic [pst_pkg::CNT_OUT_W-1:0]     item_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > pst_pkg::POS_W) ? CW : pst_pkg::POS_W;
  localparam int SW = (ITEM_WIDTH < pst_pkg::VALUE_W) ? ITEM_WIDTH : pst_pkg::VALUE_W;

  logic [CW-1:0] count;
  logic [CW-1:0] src;
  logic [CW-1:0] src_d;
  logic [CW-1:0] dst;
  logic [CW-1:0] pos_r;
  logic [SW-1:0] v_r;
  logic          rd_v;

  logic          w_ok;
  logic [CW-1:0] w_pos;
  logic [SW-1:0] w_val;
  logic [CW-1:0] w_rem;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic          rd_issue;
  logic [CW-1:0] rd_addr;
  logic [SW-1:0] rd_data;
  logic          match;
  logic          skip;
  logic          compact_wr;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [SW-1:0] wr_data;

  assign pos_ext = PW'(position);
  assign cnt_ext = PW'(count);

  assign match = cmd.cmp_ge ? (rd_data >= v_r) : (rd_data == v_r);
  assign skip  = cmd.skip_pos ? (src_d == pos_r) : (rd_data == v_r);

  assign st.pos_le     = (pos_ext <= cnt_ext);
  assign st.pos_lt     = (pos_ext < cnt_ext);
  assign st.full       = (count >= CW'(CAPACITY));
  assign st.hit        = rd_v && match;
  assign st.reads_done = !rd_v && (src >= count);
  assign st.shift_end  = !rd_v && (src <= pos_r);
  assign st.out_free   = !out_valid || !out_stall;

  // reads run ahead of the writes they feed: each write uses the data read in the cycle before
  assign rd_issue = ((cmd.scan_run || cmd.compact_run) && (src < count))
                 || (cmd.shift_run && (src > pos_r))
                 || cmd.get_rd;

  always_comb begin
    if (cmd.get_rd) begin
      rd_addr = pos_r;
    end else if (cmd.shift_run) begin
      rd_addr = src - CW'(1);
    end else begin
      rd_addr = src;
    end
  end

  assign compact_wr = cmd.compact_run && rd_v && !skip;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = v_r;
    if (cmd.shift_run && rd_v) begin
      wr_en   = 1'b1;
      wr_addr = src_d + CW'(1);
      wr_data = rd_data;
    end else if (compact_wr) begin
      wr_en   = 1'b1;
      wr_addr = dst;
      wr_data = rd_data;
    end else if (cmd.put || cmd.set_wr) begin
      wr_en = 1'b1;
    end
  end

  pst_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_issue),
    .rd_addr (rd_addr[AW-1:0]),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v <= rd_issue;
      if (cmd.put) begin
        count <= count + CW'(1);
      end else if (cmd.compact_fin) begin
        count <= dst;
      end
      if (cmd.send) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pointers and working result
  always_ff @(posedge clk) begin
    src_d <= rd_addr;
    if (cmd.load) begin
      src   <= cmd.src_top ? count : '0;
      dst   <= '0;
      pos_r <= pos_ext[CW-1:0];
      v_r   <= item_value[SW-1:0];
      w_ok  <= 1'b0;
      w_pos <= '0;
      w_val <= '0;
      w_rem <= '0;
    end else begin
      if (cmd.shift_init) begin
        src <= count;
      end else if (rd_issue && !cmd.get_rd) begin
        src <= cmd.shift_run ? src - CW'(1) : src + CW'(1);
      end
      if (compact_wr) begin
        dst <= dst + CW'(1);
      end
      if (cmd.take_scan) begin
        pos_r <= st.hit ? src_d : count;
      end
      if (cmd.put) begin
        w_ok  <= 1'b1;
        w_pos <= pos_r;
      end
      if (cmd.find_take) begin
        w_ok  <= 1'b1;
        w_pos <= src_d;
      end
      if (cmd.compact_fin) begin
        w_ok <= 1'b1;
        if (cmd.report_removed) begin
          w_rem <= count - dst;
        end
      end
      if (cmd.get_take) begin
        w_ok  <= 1'b1;
        w_val <= rd_data;
      end
      if (cmd.set_wr) begin
        w_ok <= 1'b1;
      end
    end
  end

  // output register, held while the far side stalls
  always_ff @(posedge clk) begin
    if (cmd.send) begin
      ok              <= w_ok;
      result_position <= pst_pkg::RPOS_W'(w_pos);
      result_value    <= pst_pkg::VALUE_W'(w_val);
      removed_count   <= pst_pkg::CNT_OUT_W'(w_rem);
      item_count      <= pst_pkg::CNT_OUT_W'(count);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> (count < CW'(CAPACITY)) && (pos_r <= count))
    else $error("insert into full store or past the end");

  // compaction writes never overtake the reads
  assert property (@(posedge clk) disable iff (rst)
    compact_wr |-> (dst <= src_d) && (src_d < src))
    else $error("compaction write overtook read pointer");

  assert property (@(posedge clk) disable iff (rst)
    cmd.send |-> !out_valid || !out_stall)
    else $error("result overwritten while output stalled");

endmodule

### hdl/positional_sequence_table.sv
// top level of the positional sequence table
// depends on pst_pkg, pst_controller, pst_datapath (which holds pst_ram)
`timescale 1ns / 1ps

// Ordered sequence of up to CAPACITY items in one single-port-per-direction memory,
// with a count. Each transaction carries one of insert_at, insert_sorted, erase_at,
// remove_all, get, set or find and yields exactly one result, which also reports
// the count afterwards. One transaction is worked at a time; in_stall is high from
// acceptance until the result is loaded into the output register, and the next
// transaction is taken while that result still waits on out_stall. The time per
// transaction is set by the memory passes, one stored item per cycle: get and set
// touch one entry, a failed request makes no pass, erase_at and remove_all read
// the whole list, insert_at shifts the tail from the position up, find scans up
// to a match, insert_sorted scans to the insert point, then shifts the tail up.
// No clearing pass after reset.
module positional_sequence_table #(
  parameter int CAPACITY   = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pst_pkg::OP_W-1:0]          operation,
  input  logic [pst_pkg::POS_W-1:0]         position,
  input  logic [pst_pkg::VALUE_W-1:0]       item_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              ok,
  output logic [pst_pkg::RPOS_W-1:0]        result_position,
  output logic [pst_pkg::VALUE_W-1:0]       result_value,
  output logic [pst_pkg::CNT_OUT_W-1:0]     removed_count,
  output logic [pst_pkg::CNT_OUT_W-1:0]     item_count
);

  pst_pkg::cmd_t    cmd;
  pst_pkg::status_t st;

  pst_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .st        (st),
    .cmd       (cmd)
  );

  pst_datapath #(
    .CAPACITY   (CAPACITY),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .position        (position),
    .item_value      (item_value),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .ok              (ok),
    .result_position (result_position),
    .result_value    (result_value),
    .removed_count   (removed_count),
    .item_count      (item_count)
  );

endmodule
